[src/sils_pkg.sv]
// Shared types and constants for the sorted insertion list store.
package sils_pkg;

    // Number of cells in the chain
    localparam int CAPACITY = 16;
    // Width of the fill count, wide enough to hold CAPACITY itself
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int DATA_W = 32;

    // Request commands
    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_SORTED     = 2'd2,
        CMD_READ       = 2'd3
    } cmd_e_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPORT,
        ST_READ
    } state_e_t;

    // What every cell does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTATE
    } cell_op_e_t;

    // Request payload
    typedef struct packed {
        cmd_e_t                    command;
        logic signed [DATA_W-1:0]  value;
    } req_t;

    // Result payload
    typedef struct packed {
        logic signed [DATA_W-1:0]  entry;
        logic                      entry_valid;
        logic                      last;
        logic [COUNT_W-1:0]        count;
        logic                      in_order;
        logic                      dropped;
    } rsp_t;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        cell_op_e_t                op;
        cmd_e_t                    command;
        logic signed [DATA_W-1:0]  value;
    } cell_ctl_t;

    // Where a cell sits relative to the current fill
    typedef struct packed {
        logic occupied;
        logic tail;
        logic first;
    } cell_pos_t;

endpackage

[src/sorted_insert_list_store_top.sv]
// Sorted insertion list store: controller and chain of list cells.
//
// A request is taken when start is high and busy is low. Push front, push back
// and sorted insert each give one result, on strobe after the report step that
// follows the request; the block is busy during the report step, so it takes no
// new request until that step is over. The report step evaluates the order
// flag across the whole cell chain after the shift. A read out of n entries gives
// n results on consecutive cycles, one per rotation of the chain, each registered
// from the head cell; busy stays high until the last entry is read, and an empty
// read out gives one result like an update. A request to a full list is refused,
// flagged by dropped, and takes the same time as an update. Results cannot be
// held off: each is valid on the result port only in the one cycle that strobe marks it.
module sorted_insert_list_store_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sils_pkg::req_t  req,
    output sils_pkg::rsp_t  result,
    output logic            strobe
);

    localparam logic [sils_pkg::COUNT_W-1:0] FULL = sils_pkg::COUNT_W'(sils_pkg::CAPACITY);
    localparam logic [sils_pkg::COUNT_W-1:0] ONE  = sils_pkg::COUNT_W'(1);

    sils_pkg::state_e_t                 state_reg, state_next;
    logic [sils_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [sils_pkg::COUNT_W-1:0]       idx_reg, idx_next;
    logic                               drop_reg, drop_next;
    logic                               order_reg, order_next;
    sils_pkg::rsp_t                     out_reg, out_next;
    logic                               strobe_reg, strobe_next;

    sils_pkg::cell_ctl_t                ctl;
    sils_pkg::cell_pos_t                pos [sils_pkg::CAPACITY];
    logic signed [sils_pkg::DATA_W-1:0] ent [sils_pkg::CAPACITY];
    logic                               at_c [sils_pkg::CAPACITY+1];
    logic                               ok_c [sils_pkg::CAPACITY+1];

    logic accept;
    logic is_read;
    logic full;
    logic read_last;
    logic in_order_now;

    assign accept       = start && !busy;
    assign is_read      = (req.command == sils_pkg::CMD_READ);
    assign full         = (count_reg == FULL);
    assign read_last    = (idx_reg == count_reg - ONE);
    assign in_order_now = ok_c[sils_pkg::CAPACITY];

    assign busy   = (state_reg != sils_pkg::ST_IDLE);
    assign result = out_reg;
    assign strobe = strobe_reg;

    // Chain ends
    assign at_c[0] = 1'b0;
    assign ok_c[0] = 1'b1;

    // Cell chain
    for (genvar i = 0; i < sils_pkg::CAPACITY; i++)
    begin : g_cell
        localparam logic [sils_pkg::COUNT_W-1:0] IDX = sils_pkg::COUNT_W'(i);
        logic signed [sils_pkg::DATA_W-1:0] prev_e;
        logic signed [sils_pkg::DATA_W-1:0] next_e;

        assign pos[i].occupied = (IDX < count_reg);
        assign pos[i].tail     = (IDX == count_reg - ONE);
        assign pos[i].first    = (i == 0);

        if (i == 0)
        begin : g_head
            assign prev_e = ctl.value;
        end
        else
        begin : g_body
            assign prev_e = ent[i-1];
        end

        if (i == sils_pkg::CAPACITY - 1)
        begin : g_end
            assign next_e = ent[0];
        end
        else
        begin : g_mid
            assign next_e = ent[i+1];
        end

        sils_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos[i]),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .wrap_entry (ent[0]),
            .at_in      (at_c[i]),
            .ok_in      (ok_c[i]),
            .entry      (ent[i]),
            .at_out     (at_c[i+1]),
            .ok_out     (ok_c[i+1])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sils_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_read && (count_reg != '0))
                        state_next = sils_pkg::ST_READ;
                    else
                        state_next = sils_pkg::ST_REPORT;
                end
            end
            sils_pkg::ST_REPORT:
                state_next = sils_pkg::ST_IDLE;
            sils_pkg::ST_READ:
            begin
                if (read_last)
                    state_next = sils_pkg::ST_IDLE;
            end
            default:
                state_next = sils_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        ctl.op      = sils_pkg::OP_HOLD;
        ctl.command = req.command;
        ctl.value   = req.value;
        count_next  = count_reg;
        idx_next    = idx_reg;
        drop_next   = drop_reg;
        order_next  = order_reg;
        out_next    = out_reg;
        strobe_next = 1'b0;
        case (state_reg)
            sils_pkg::ST_IDLE:
            begin
                idx_next  = '0;
                drop_next = 1'b0;
                if (accept && !is_read)
                begin
                    if (full)
                        drop_next = 1'b1;
                    else
                    begin
                        ctl.op     = sils_pkg::OP_INSERT;
                        count_next = count_reg + ONE;
                    end
                end
            end
            sils_pkg::ST_REPORT:
            begin
                order_next           = in_order_now;
                out_next.entry       = '0;
                out_next.entry_valid = 1'b0;
                out_next.last        = 1'b1;
                out_next.count       = count_reg;
                out_next.in_order    = in_order_now;
                out_next.dropped     = drop_reg;
                strobe_next          = 1'b1;
            end
            sils_pkg::ST_READ:
            begin
                ctl.op               = sils_pkg::OP_ROTATE;
                idx_next             = idx_reg + ONE;
                out_next.entry       = ent[0];
                out_next.entry_valid = 1'b1;
                out_next.last        = read_last;
                out_next.count       = count_reg;
                out_next.in_order    = order_reg;
                out_next.dropped     = 1'b0;
                strobe_next          = 1'b1;
            end
            default:
                ctl.op = sils_pkg::OP_HOLD;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sils_pkg::ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            drop_reg   <= 1'b0;
            order_reg  <= 1'b1;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            drop_reg   <= drop_next;
            order_reg  <= order_next;
            strobe_reg <= strobe_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    // Fill never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("fill count beyond capacity");

    // An accepted update to a non-full list grows the fill by one
    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_read && !full) |=> (count_reg == $past(count_reg) + ONE))
        else $error("fill count did not grow on insert");

    // Report step always produces a single final result
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sils_pkg::ST_REPORT) |=> (strobe && result.last && !result.entry_valid))
        else $error("report step gave no final result");

    // Every read-out cycle produces a valid entry
    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sils_pkg::ST_READ) |=> (strobe && result.entry_valid))
        else $error("read out cycle gave no entry");

    // Read out never changes the fill
    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sils_pkg::ST_READ) |=> $stable(count_reg))
        else $error("fill changed during read out");
`endif

endmodule

[src/sils_cell.sv]
// One cell of the list chain: holds one entry, inserts, shifts and rotates.
module sils_cell (
    input  logic                                clk,
    input  sils_pkg::cell_ctl_t                 ctl,
    input  sils_pkg::cell_pos_t                 pos,
    input  logic signed [sils_pkg::DATA_W-1:0]  prev_entry,
    input  logic signed [sils_pkg::DATA_W-1:0]  next_entry,
    input  logic signed [sils_pkg::DATA_W-1:0]  wrap_entry,
    input  logic                                at_in,
    input  logic                                ok_in,
    output logic signed [sils_pkg::DATA_W-1:0]  entry,
    output logic                                at_out,
    output logic                                ok_out
);

    logic signed [sils_pkg::DATA_W-1:0] entry_reg;
    logic signed [sils_pkg::DATA_W-1:0] entry_next;
    logic signed [sils_pkg::DATA_W-1:0] val;
    logic                               goes_here;
    logic                               local_at;

    assign val   = ctl.value;
    assign entry = entry_reg;

    // Sorted position test: front cell takes value <= entry, later cells need entry > value
    assign goes_here = pos.occupied && (pos.first ? (val <= entry_reg) : (entry_reg > val));

    // Insertion point lies at or before this cell
    assign local_at = (ctl.command == sils_pkg::CMD_PUSH_FRONT) || !pos.occupied
                      || ((ctl.command == sils_pkg::CMD_SORTED) && goes_here);
    assign at_out   = at_in || local_at;

    // Order check against the neighbour in front
    assign ok_out = ok_in && (pos.first || !pos.occupied || !(entry_reg < prev_entry));

    // Next entry
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            sils_pkg::OP_INSERT:
            begin
                if (at_in)
                    entry_next = prev_entry;
                else if (at_out)
                    entry_next = val;
            end
            sils_pkg::OP_ROTATE:
            begin
                if (pos.occupied)
                    entry_next = pos.tail ? wrap_entry : next_entry;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[tb/sv/tb_sorted_insert_list_store_top.sv]
// Self-checking testbench for the sorted insertion list store.
`timescale 1ns / 1ps

module tb_sorted_insert_list_store_top;

    import sils_pkg::*;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_PERCENT = 16;
    localparam int SETTLE_CYCLES = 8;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    req_t   req;
    rsp_t   result;
    logic   strobe;

    // Shadow copy of the list held by the block
    logic signed [DATA_W-1:0] list_image [CAPACITY];
    int                       list_len;

    // Results predicted but not yet seen
    rsp_t   pending_results [$];
    int     mismatches;
    bit     idle_enabled;

    sorted_insert_list_store_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .result (result),
        .strobe (strobe)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
    begin
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    end
    endtask

    // Non-decreasing check over the shadow list
    function automatic logic list_is_ordered();
        int i;
    begin
        for (i = 1; i < list_len; i++)
        begin
            if (list_image[i] < list_image[i-1])
                return 1'b0;
        end
        return 1'b1;
    end
    endfunction

    // Work out the results of one accepted request and update the shadow list
    task automatic predict_list_step(input req_t r);
        rsp_t want;
        int   pos;
        int   i;
    begin
        want = '0;
        want.last = 1'b1;
        if (r.command == CMD_READ)
        begin
            want.count = COUNT_W'(list_len);
            want.in_order = list_is_ordered();
            if (list_len == 0)
                pending_results.push_back(want);
            else
            begin
                for (i = 0; i < list_len; i++)
                begin
                    want.entry = list_image[i];
                    want.entry_valid = 1'b1;
                    want.last = (i == list_len - 1);
                    pending_results.push_back(want);
                end
            end
        end
        else if (list_len >= CAPACITY)
        begin
            // full list: refused, nothing moves
            want.dropped = 1'b1;
            want.count = COUNT_W'(list_len);
            want.in_order = list_is_ordered();
            pending_results.push_back(want);
        end
        else
        begin
            case (r.command)
                CMD_PUSH_FRONT: pos = 0;
                CMD_PUSH_BACK:  pos = list_len;
                default:
                begin
                    if (list_len == 0 || r.value <= list_image[0])
                        pos = 0;
                    else
                    begin
                        pos = 1;
                        while (pos < list_len && list_image[pos] <= r.value)
                            pos++;
                    end
                end
            endcase
            for (i = list_len; i > pos; i--)
                list_image[i] = list_image[i-1];
            list_image[pos] = r.value;
            list_len++;
            want.count = COUNT_W'(list_len);
            want.in_order = list_is_ordered();
            pending_results.push_back(want);
        end
    end
    endtask

    // Present one request and hold it until the block takes it
    task automatic send_request(input cmd_e_t cmd, input logic signed [DATA_W-1:0] val);
        req_t r;
        bit   taken;
    begin
        r.command = cmd;
        r.value = val;
        @(negedge clk);
        start <= 1'b1;
        req <= r;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken = 1'b1;
                predict_list_step(r);
            end
        end
    end
    endtask

    // Occasional gap on the request side
    task automatic idle_gap();
    begin
        if (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
    end
    endtask

    // Hold off requests until every predicted result has come back
    task automatic drain_results();
    begin
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    end
    endtask

    task automatic test_empty_readout();
    begin
        send_request(CMD_READ, VAL_MAX);
        drain_results();
    end
    endtask

    // Empty list, equal to first, below first, at the end, middle, equal in middle
    task automatic test_sorted_insert();
    begin
        send_request(CMD_SORTED, 32'sd0);
        send_request(CMD_SORTED, 32'sd0);
        send_request(CMD_SORTED, VAL_MIN);
        send_request(CMD_SORTED, VAL_MAX);
        send_request(CMD_SORTED, 32'sd7);
        send_request(CMD_SORTED, 32'sd7);
        send_request(CMD_READ, 32'sd0);
        drain_results();
    end
    endtask

    // Pushes at both ends break the ordering
    task automatic test_push_ends();
    begin
        send_request(CMD_PUSH_FRONT, VAL_MAX);
        send_request(CMD_PUSH_BACK, VAL_MIN);
        send_request(CMD_PUSH_FRONT, -32'sd1);
        send_request(CMD_PUSH_BACK, 32'sd1);
        send_request(CMD_READ, -32'sd1);
        drain_results();
    end
    endtask

    // Random mix of updates and read outs
    task automatic test_random_mix();
        int                       n;
        cmd_e_t                   cmd;
        logic signed [DATA_W-1:0] val;
    begin
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_enabled = !(n >= 150 && n < 300);
            if ($urandom_range(0, 99) < 30)
                cmd = CMD_READ;
            else
                cmd = cmd_e_t'($urandom_range(0, 2));
            // small values give plenty of ties
            if ($urandom_range(0, 3) == 0)
                val = $signed(32'($urandom_range(0, 6))) - 32'sd3;
            else
                val = $urandom;
            send_request(cmd, val);
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            else
                idle_gap();
        end
        idle_enabled = 1'b1;
        drain_results();
    end
    endtask

    // Fill up, then every update must be refused
    task automatic test_full_list();
    begin
        while (list_len < CAPACITY)
            send_request(CMD_SORTED, $urandom);
        send_request(CMD_PUSH_FRONT, VAL_MIN);
        send_request(CMD_PUSH_BACK, VAL_MAX);
        send_request(CMD_SORTED, 32'sd0);
        send_request(CMD_READ, 32'sd0);
        drain_results();
    end
    endtask

    // Compare every strobed result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request pending");
            else
            begin
                want = pending_results.pop_front();
                if (result.entry !== want.entry)
                    report_mismatch($sformatf("entry got %0d want %0d",
                                              result.entry, want.entry));
                if (result.entry_valid !== want.entry_valid)
                    report_mismatch($sformatf("entry_valid got %b want %b",
                                              result.entry_valid, want.entry_valid));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last got %b want %b",
                                              result.last, want.last));
                if (result.count !== want.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              result.count, want.count));
                if (result.in_order !== want.in_order)
                    report_mismatch($sformatf("in_order got %b want %b",
                                              result.in_order, want.in_order));
                if (result.dropped !== want.dropped)
                    report_mismatch($sformatf("dropped got %b want %b",
                                              result.dropped, want.dropped));
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        list_len = 0;
        mismatches = 0;
        idle_enabled = 1'b1;
        foreach (list_image[i])
            list_image[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_readout();
        test_sorted_insert();
        test_push_ends();
        test_random_mix();
        test_full_list();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS sorted_insert_list_store_top");
        else
            $display("FAIL sorted_insert_list_store_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("FAIL sorted_insert_list_store_top");
        $finish;
    end

endmodule
